// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Types, codes and helpers shared by the sorted statement range table.
// ----------------------------------------------------------------------------
package sst_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	// scan index wide enough for the entry count and for prev_index + 1
	localparam int SCAN_W      = (CNT_W > 9) ? CNT_W : 9;

	// request commands
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// tag kinds
	localparam logic [1:0] KIND_NONE      = 2'd0;
	localparam logic [1:0] KIND_STMT      = 2'd1;
	localparam logic [1:0] KIND_BLOCK     = 2'd2;
	localparam logic [1:0] KIND_STATIC_IF = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_EMPTY    = 3'd1;
	localparam logic [2:0] STAT_EXCLUDED = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_NOMATCH  = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic [31:0] start_address;
		logic [31:0] end_address;
		logic [1:0]  tag_kind;
		logic [15:0] source_file;
		logic [23:0] source_line;
		logic [31:0] position;
		logic        prev_valid;
		logic [7:0]  prev_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  hit_index;
		logic [31:0] hit_start;
		logic [31:0] hit_end;
		logic        hit_has_source;
		logic [15:0] hit_file;
		logic [23:0] hit_line;
	} rsp_t;

	// one table entry as held in memory
	typedef struct packed {
		logic [31:0] rng_start;
		logic [31:0] rng_end;
		logic        has_src;
		logic [15:0] file;
		logic [23:0] line;
	} entry_t;

	// result for a rejected insert or a failed lookup
	function automatic rsp_t rsp_fail(input logic [2:0] st);
		rsp_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	// result reporting one entry
	function automatic rsp_t rsp_entry(input logic [7:0] idx, input entry_t e);
		rsp_t r;
		r.status         = STAT_OK;
		r.hit_index      = idx;
		r.hit_start      = e.rng_start;
		r.hit_end        = e.rng_end;
		r.hit_has_source = e.has_src;
		r.hit_file       = e.file;
		r.hit_line       = e.line;
		return r;
	endfunction

endpackage

// ===== rtl/sst_if.sv =====
// ----------------------------------------------------------------------------
// sst_req_if / sst_rsp_if
// Valid/ready channels carrying table requests and their results.
// ----------------------------------------------------------------------------
interface sst_req_if import sst_pkg::*;;
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*;;
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/sst_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// sst_rsp_reg
// Output register for results; frees the table engine from the consumer.
// ----------------------------------------------------------------------------
module sst_rsp_reg import sst_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rsp_t          push_data,
	output logic          free,
	sst_rsp_if.source     rsp
);

	logic valid_q;
	rsp_t data_q;

	// slot can take a result when empty or being drained this cycle
	assign free      = !valid_q || rsp.ready;
	assign rsp.valid = valid_q;
	assign rsp.data  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

// ===== rtl/sorted_statement_range_table.sv =====
// ----------------------------------------------------------------------------
// sorted_statement_range_table
// Address range table kept sorted by start address, with insert and lookup.
// ----------------------------------------------------------------------------
//  channel  direction  payload  request
//  req      in         req_t    insert a range or look up a position
//  rsp      out        rsp_t    one result for every request
//
//  An insert scans down, moving each entry whose start is not below its own
//  up one slot, then writes its entry; a lookup scans up from entry 0 or
//  prev_index + 1. The dual-port table memory moves one entry a cycle.
//  Rejected requests go straight to the result. After reset the table is
//  empty and ready at once. A stalled rsp holds the engine only in S_EMIT.
// ----------------------------------------------------------------------------
module sorted_statement_range_table import sst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sst_req_if.sink   req,
	sst_rsp_if.source rsp
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_INS_SCAN = 5'b00010,
		S_INS_PUT  = 5'b00100,
		S_LKP_SCAN = 5'b01000,
		S_EMIT     = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [SCAN_W-1:0] k_q, k_d;
	logic [CNT_W-1:0]  count_q, count_d;
	req_t              req_q;
	rsp_t              res_q, res_d;

	entry_t            mem [TABLE_DEPTH];
	entry_t            rd_data_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;

	logic              req_fire;
	logic              rsp_free;
	logic              push;
	logic [SCAN_W-1:0] kp1;
	logic [SCAN_W-1:0] lkp_first;
	logic [SCAN_W-1:0] count_ext;
	entry_t            new_entry;
	logic              hit;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign kp1       = k_q + SCAN_W'(1);
	assign count_ext = SCAN_W'(count_q);
	assign lkp_first = req.data.prev_valid ?
		(SCAN_W'(req.data.prev_index) + SCAN_W'(1)) : '0;

	// entry built from the latched insert request
	always_comb begin
		new_entry.rng_start = req_q.start_address;
		new_entry.rng_end   = req_q.end_address;
		new_entry.has_src   = (req_q.tag_kind == KIND_STMT);
		new_entry.file      = (req_q.tag_kind == KIND_STMT) ? req_q.source_file : '0;
		new_entry.line      = (req_q.tag_kind == KIND_STMT) ? req_q.source_line : '0;
	end

	// half-open range test for the entry just read
	assign hit = (req_q.position >= rd_data_q.rng_start) &&
		(req_q.position < rd_data_q.rng_end);

	// sequencer: insert scans down shifting entries up, lookup scans up
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		count_d = count_q;
		res_d   = res_q;
		rd_addr = k_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = k_q[IDX_W-1:0];
		wr_data = rd_data_q;
		push    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.data.cmd == CMD_INSERT) begin
						priority if (!(req.data.start_address < req.data.end_address)) begin
							res_d   = rsp_fail(STAT_EMPTY);
							state_d = S_EMIT;
						end else if (req.data.tag_kind == KIND_BLOCK ||
							req.data.tag_kind == KIND_STATIC_IF) begin
							res_d   = rsp_fail(STAT_EXCLUDED);
							state_d = S_EMIT;
						end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
							res_d   = rsp_fail(STAT_FULL);
							state_d = S_EMIT;
						end else if (count_q == '0) begin
							k_d     = '0;
							state_d = S_INS_PUT;
						end else begin
							k_d     = count_ext - SCAN_W'(1);
							rd_addr = k_d[IDX_W-1:0];
							state_d = S_INS_SCAN;
						end
					end else begin
						if (lkp_first >= count_ext) begin
							res_d   = rsp_fail(STAT_NOMATCH);
							state_d = S_EMIT;
						end else begin
							k_d     = lkp_first;
							rd_addr = lkp_first[IDX_W-1:0];
							state_d = S_LKP_SCAN;
						end
					end
				end
			end
			S_INS_SCAN: begin
				if (rd_data_q.rng_start >= req_q.start_address) begin
					// move this entry one slot up
					wr_en   = 1'b1;
					wr_addr = kp1[IDX_W-1:0];
					wr_data = rd_data_q;
					if (k_q == '0) begin
						state_d = S_INS_PUT;
					end else begin
						k_d     = k_q - SCAN_W'(1);
						rd_addr = k_d[IDX_W-1:0];
					end
				end else begin
					k_d     = kp1;
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = k_q[IDX_W-1:0];
				wr_data = new_entry;
				count_d = count_q + CNT_W'(1);
				res_d   = rsp_entry(k_q[7:0], new_entry);
				state_d = S_EMIT;
			end
			S_LKP_SCAN: begin
				if (hit) begin
					res_d   = rsp_entry(k_q[7:0], rd_data_q);
					state_d = S_EMIT;
				end else if (kp1 >= count_ext) begin
					res_d   = rsp_fail(STAT_NOMATCH);
					state_d = S_EMIT;
				end else begin
					k_d     = kp1;
					rd_addr = kp1[IDX_W-1:0];
				end
			end
			S_EMIT: begin
				if (rsp_free) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		k_q   <= k_d;
		res_q <= res_d;
		if (req_fire) begin
			req_q <= req.data;
		end
	end

	// table memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// result register
	sst_rsp_reg u_rsp_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_q),
		.free      (rsp_free),
		.rsp       (rsp)
	);

	// entry count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// a completed insert grows the table by exactly one entry
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_PUT |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not bump entry count");

	// lookup never looks at entries past the valid ones
	a_lkp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LKP_SCAN |-> k_q < count_ext)
		else $error("lookup scan beyond entry count");

	// memory is only written while an insert is under way
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_INS_SCAN || state_q == S_INS_PUT))
		else $error("table write outside insert");

	// a pushed result returns the sequencer to idle
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> state_q == S_IDLE)
		else $error("result pushed without returning to idle");

endmodule

// ===== dv/tb_sorted_statement_range_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_statement_range_table
// Drives insert and lookup requests into the range table under varied flow
// control and checks every result against a behavioural copy of the table.
// ----------------------------------------------------------------------------
module tb_sorted_statement_range_table;
	import sst_pkg::*;

	logic clk;
	logic arst_n;

	sst_req_if req_ch();
	sst_rsp_if rsp_ch();

	sorted_statement_range_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// behavioural copy of the table and the results still owed
	entry_t      range_tbl [TABLE_DEPTH];
	int unsigned range_cnt;
	rsp_t        pending_rsp [$];

	// flow control knobs
	int send_idle_pct;
	int rsp_stall_pct;
	int rsp_hold_left;

	// bookkeeping
	int fail_cnt;
	int req_cnt;
	int checked_cnt;
	int status_cnt [5];

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result for the entry at a given slot
	function automatic rsp_t slot_result(input int unsigned slot);
		rsp_t res;
		res.status         = STAT_OK;
		res.hit_index      = slot[7:0];
		res.hit_start      = range_tbl[slot].rng_start;
		res.hit_end        = range_tbl[slot].rng_end;
		res.hit_has_source = range_tbl[slot].has_src;
		res.hit_file       = range_tbl[slot].file;
		res.hit_line       = range_tbl[slot].line;
		return res;
	endfunction

	// apply one request to the table copy and work out its result
	function automatic rsp_t table_update(input req_t r);
		rsp_t        res;
		int unsigned slot;
		int unsigned j;
		res = '0;
		if (r.cmd == CMD_INSERT) begin
			if (r.start_address >= r.end_address) begin
				res.status = STAT_EMPTY;
			end else if (r.tag_kind == KIND_BLOCK || r.tag_kind == KIND_STATIC_IF) begin
				res.status = STAT_EXCLUDED;
			end else if (range_cnt >= TABLE_DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				// new entry goes ahead of any entry with an equal start
				slot = 0;
				while (slot < range_cnt && r.start_address > range_tbl[slot].rng_start)
					slot++;
				for (j = range_cnt; j > slot; j--)
					range_tbl[j] = range_tbl[j - 1];
				range_tbl[slot].rng_start = r.start_address;
				range_tbl[slot].rng_end   = r.end_address;
				range_tbl[slot].has_src   = (r.tag_kind == KIND_STMT);
				range_tbl[slot].file      = (r.tag_kind == KIND_STMT) ? r.source_file : '0;
				range_tbl[slot].line      = (r.tag_kind == KIND_STMT) ? r.source_line : '0;
				range_cnt++;
				res = slot_result(slot);
			end
		end else begin
			// first half-open range holding the position, past prev_index if asked
			res.status = STAT_NOMATCH;
			for (j = 0; j < range_cnt; j++) begin
				if (r.position >= range_tbl[j].rng_start && r.position < range_tbl[j].rng_end &&
						(!r.prev_valid || j > r.prev_index)) begin
					res = slot_result(j);
					break;
				end
			end
		end
		return res;
	endfunction

	function automatic req_t make_insert(input logic [31:0] start_a, input logic [31:0] end_a,
			input logic [1:0] kind, input logic [15:0] file, input logic [23:0] line);
		req_t r;
		r.cmd           = CMD_INSERT;
		r.start_address = start_a;
		r.end_address   = end_a;
		r.tag_kind      = kind;
		r.source_file   = file;
		r.source_line   = line;
		r.position      = $urandom();
		r.prev_valid    = 1'($urandom_range(1));
		r.prev_index    = 8'($urandom_range(255));
		return r;
	endfunction

	function automatic req_t make_lookup(input logic [31:0] pos, input logic pv,
			input logic [7:0] pidx);
		req_t r;
		r.cmd           = CMD_LOOKUP;
		r.start_address = $urandom();
		r.end_address   = $urandom();
		r.tag_kind      = 2'($urandom_range(3));
		r.source_file   = 16'($urandom_range(16'hFFFF));
		r.source_line   = 24'($urandom_range(24'hFF_FFFF));
		r.position      = pos;
		r.prev_valid    = pv;
		r.prev_index    = pidx;
		return r;
	endfunction

	// well-formed insert, often into a small address window so starts collide
	function automatic req_t random_good_insert();
		logic [31:0] start_a;
		logic [31:0] end_a;
		logic [31:0] len;
		logic [1:0]  kind;
		kind = $urandom_range(1) ? KIND_STMT : KIND_NONE;
		if ($urandom_range(99) < 45) begin
			start_a = $urandom_range(63) * 16;
			end_a   = start_a + $urandom_range(64, 1);
		end else begin
			start_a = $urandom();
			len     = $urandom() >> $urandom_range(31);
			if (len == 0)
				len = 1;
			end_a = start_a + len;
			if (end_a < start_a)
				end_a = '1;
		end
		return make_insert(start_a, end_a, kind, 16'($urandom_range(16'hFFFF)),
			24'($urandom_range(24'hFF_FFFF)));
	endfunction

	// random request shaped by what the table currently holds
	function automatic req_t random_request();
		req_t        r;
		int unsigned k;
		int unsigned sel;
		entry_t      e;
		sel = $urandom_range(99);
		if (sel < 36) begin
			r = random_good_insert();
		end else if (sel < 45) begin
			// malformed insert: any kind, raw bounds, sometimes an empty range
			r = make_insert($urandom(), $urandom(), 2'($urandom_range(3)),
				16'($urandom_range(16'hFFFF)), 24'($urandom_range(24'hFF_FFFF)));
			if ($urandom_range(3) == 0)
				r.end_address = r.start_address;
		end else begin
			r = make_lookup($urandom(), 1'($urandom_range(1)), 8'($urandom_range(255)));
			if (range_cnt > 0 && $urandom_range(99) < 85) begin
				k = $urandom_range(range_cnt - 1);
				e = range_tbl[k];
				sel = $urandom_range(99);
				if (sel < 75)
					r.position = e.rng_start + $urandom_range(e.rng_end - e.rng_start - 1);
				else if (sel < 87)
					r.position = e.rng_end;
				else
					r.position = e.rng_start - 1;
				// previous index near the target entry
				if ($urandom_range(1))
					r.prev_index = 8'(k + $urandom_range(3) - 2);
			end
		end
		return r;
	endfunction

	task automatic set_traffic(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
	endtask

	// offer one request, with a random idle gap first, and predict its result
	task automatic send_request(input req_t r);
		rsp_t want;
		int   gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		want = table_update(r);
		pending_rsp.push_back(want);
		status_cnt[want.status]++;
		req_cnt++;
	endtask

	// drop valid and wait for every owed result
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// extremes, empty and excluded rejections, equal starts and the prev_index rule
	task automatic test_directed();
		set_traffic(0, 0);
		send_request(make_lookup(32'h0, 1'b0, 8'd0));
		send_request(make_lookup('1, 1'b1, 8'd255));
		send_request(make_insert(32'h5, 32'h5, KIND_STMT, 16'h1, 24'h1));
		send_request(make_insert('1, 32'h0, KIND_NONE, 16'h2, 24'h2));
		send_request(make_insert(32'h10, 32'h5, KIND_BLOCK, 16'h3, 24'h3));
		send_request(make_insert(32'h100, 32'h200, KIND_BLOCK, 16'h4, 24'h4));
		send_request(make_insert(32'h100, 32'h200, KIND_STATIC_IF, 16'h5, 24'h5));
		send_request(make_insert(32'h0, '1, KIND_NONE, '1, '1));
		send_request(make_insert(32'h100, 32'h200, KIND_STMT, '1, '1));
		send_request(make_insert(32'h100, 32'h180, KIND_STMT, 16'h1234, 24'h56));
		send_request(make_insert(32'hFFFF_FFFE, '1, KIND_STMT, 16'h0, 24'h0));
		send_request(make_insert(32'h80, 32'h100, KIND_NONE, 16'hA5A5, 24'h5A5A5A));
		send_request(make_lookup(32'h0, 1'b0, 8'd0));
		send_request(make_lookup(32'h100, 1'b0, 8'd0));
		send_request(make_lookup(32'h100, 1'b1, 8'd0));
		send_request(make_lookup(32'h17F, 1'b1, 8'd2));
		send_request(make_lookup(32'h180, 1'b1, 8'd1));
		send_request(make_lookup(32'h200, 1'b1, 8'd0));
		send_request(make_lookup(32'hFFFF_FFFE, 1'b1, 8'd0));
		send_request(make_lookup('1, 1'b0, 8'd0));
		send_request(make_lookup(32'h80, 1'b0, 8'd255));
		send_request(make_lookup(32'h80, 1'b1, 8'd255));
		wait_idle();
	endtask

	task automatic test_random_traffic(input int n);
		repeat (n)
			send_request(random_request());
		wait_idle();
	endtask

	// fill to the last slot, then every insert rejection on a full table
	task automatic test_fill_table();
		set_traffic(16, 16);
		while (range_cnt < TABLE_DEPTH)
			send_request(random_good_insert());
		send_request(random_good_insert());
		send_request(make_insert(32'h40, 32'h40, KIND_STMT, 16'h7, 24'h7));
		send_request(make_insert(32'h40, 32'h80, KIND_STATIC_IF, 16'h8, 24'h8));
		send_request(make_lookup(range_tbl[TABLE_DEPTH - 1].rng_start, 1'b1, 8'd254));
		send_request(make_lookup(range_tbl[TABLE_DEPTH - 1].rng_start, 1'b1, 8'd255));
		send_request(make_lookup(range_tbl[TABLE_DEPTH - 1].rng_start, 1'b0, 8'd255));
		wait_idle();
	endtask

	// long result stall while requests keep coming, so the input backs up
	task automatic test_rsp_backpressure();
		set_traffic(0, 0);
		rsp_hold_left = 1200;
		repeat (8)
			send_request(random_request());
		wait_idle();
	endtask

	// result receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold_left--;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_cnt++;
		end
	endfunction

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: status %0h, no request outstanding",
					rsp_ch.data.status);
				fail_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				checked_cnt++;
				check_field("status", 32'(want.status), 32'(rsp_ch.data.status));
				check_field("hit_index", 32'(want.hit_index), 32'(rsp_ch.data.hit_index));
				check_field("hit_start", want.hit_start, rsp_ch.data.hit_start);
				check_field("hit_end", want.hit_end, rsp_ch.data.hit_end);
				check_field("hit_has_source", 32'(want.hit_has_source),
					32'(rsp_ch.data.hit_has_source));
				check_field("hit_file", 32'(want.hit_file), 32'(rsp_ch.data.hit_file));
				check_field("hit_line", 32'(want.hit_line), 32'(rsp_ch.data.hit_line));
			end
		end
	end

	// test sequence
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		range_cnt     = 0;
		rsp_hold_left = 0;
		fail_cnt      = 0;
		req_cnt       = 0;
		checked_cnt   = 0;
		foreach (status_cnt[i])
			status_cnt[i] = 0;
		set_traffic(0, 0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_traffic(0, 0);
		test_random_traffic(170);
		set_traffic(61, 0);
		test_random_traffic(170);
		set_traffic(0, 61);
		test_random_traffic(170);
		set_traffic(16, 16);
		test_random_traffic(170);
		test_fill_table();
		test_rsp_backpressure();
		set_traffic(30, 30);
		test_random_traffic(120);

		// let any stray result show up
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("covered %0d requests: %0d hits or stored, %0d empty, %0d excluded,",
			req_cnt, status_cnt[STAT_OK], status_cnt[STAT_EMPTY], status_cnt[STAT_EXCLUDED]);
		$display("%0d full, %0d missed; table ended with %0d entries, %0d results compared",
			status_cnt[STAT_FULL], status_cnt[STAT_NOMATCH], range_cnt, checked_cnt);
		if (fail_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#(20_000_000);
		$display("timed out with %0d results outstanding", pending_rsp.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sst_pkg.sv
rtl/sst_if.sv
rtl/sst_rsp_reg.sv
rtl/sorted_statement_range_table.sv
dv/tb_sorted_statement_range_table.sv
